/* rtl/flv_tag_header_parser_top_macros.svh */
// Assertion macros for the FLV tag header parser checker.
// Every property is clocked on clk_i and disabled while rst_ni is low.
`ifndef FLV_TAG_HEADER_PARSER_TOP_MACROS_SVH
`define FLV_TAG_HEADER_PARSER_TOP_MACROS_SVH

// Implication that must hold at every clock edge out of reset.
`define FLVP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("flvp: property violated");

// A signal that must keep its value across a stalled cycle.
`define FLVP_ASSERT_HOLD(label, cond, sig) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error("flvp: value changed while stalled");

`endif

/* rtl/flvp_pkg.sv */
// Shared types and constants of the FLV tag header parser.
// No dependencies; used by the top level and the record formatter.
`default_nettype none

package flvp_pkg;

  localparam int unsigned POS_W = 24;

  // Field lengths, in bytes, of the file header and the tag header
  localparam logic [POS_W-1:0] HDR_BYTES       = 24'd9;
  localparam logic [POS_W-1:0] HDR_KEEP_BYTES  = 24'd5;
  localparam logic [POS_W-1:0] PREV_BYTES      = 24'd4;
  localparam logic [POS_W-1:0] DSIZE_BYTES     = 24'd3;
  localparam logic [POS_W-1:0] TS_BYTES        = 24'd3;
  localparam logic [POS_W-1:0] SKIP_BYTES      = 24'd4;

  // Positions inside the data of a video tag
  localparam logic [POS_W-1:0] VID_BYTE_POS    = 24'd0;
  localparam logic [POS_W-1:0] PKT_TYPE_POS    = 24'd1;
  localparam logic [POS_W-1:0] NALU_FIRST_POS  = 24'd5;
  localparam logic [POS_W-1:0] NALU_LAST_POS   = 24'd8;
  localparam logic [POS_W-1:0] MIN_VIDEO_BYTES = 24'd5;
  localparam logic [POS_W-1:0] MIN_NALU_BYTES  = 24'd9;

  localparam logic [7:0] VIDEO_TAG     = 8'd9;
  localparam logic [7:0] PKT_TYPE_NALU = 8'd1;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_TAG    = 1'b1;

  localparam int unsigned OUT_TDATA_W = 184;
  localparam int unsigned OUT_PAD_W   = 6;

  typedef struct packed {
    logic [31:0] prev_size;
    logic [7:0]  tag_type;
    logic [23:0] data_size;
    logic [23:0] timestamp;
    logic [7:0]  video_byte;
    logic [7:0]  packet_type;
    logic [31:0] nalu_length;
  } flvp_held_t;

  typedef struct packed {
    logic        record_kind;
    logic [39:0] header_word;
    logic [31:0] previous_tag_size;
    logic [7:0]  tag_type;
    logic [23:0] data_size;
    logic [23:0] timestamp;
    logic [3:0]  frame_type;
    logic [3:0]  codec_id;
    logic [7:0]  packet_type;
    logic [31:0] nalu_length;
    logic        video_fields_valid;
    logic        nalu_valid;
  } flvp_record_t;

endpackage

`default_nettype wire

/* rtl/flvp_record_fmt.sv */
// Builds a tag record from the held tag header and video fields.
// Depends on flvp_pkg.
`default_nettype none

module flvp_record_fmt (
  input  flvp_pkg::flvp_held_t   held_i,
  output flvp_pkg::flvp_record_t rec_o
);
  import flvp_pkg::*;

  logic video;
  logic nalu;

  assign video = (held_i.tag_type == VIDEO_TAG) && (held_i.data_size >= MIN_VIDEO_BYTES);
  assign nalu  = video && (held_i.packet_type == PKT_TYPE_NALU)
              && (held_i.data_size >= MIN_NALU_BYTES);

  always_comb begin
    rec_o                    = '0;
    rec_o.record_kind        = KIND_TAG;
    rec_o.previous_tag_size  = held_i.prev_size;
    rec_o.tag_type           = held_i.tag_type;
    rec_o.data_size          = held_i.data_size;
    rec_o.timestamp          = held_i.timestamp;
    // Drop video fields that lie past a short tag's data
    rec_o.frame_type         = video ? held_i.video_byte[7:4] : 4'd0;
    rec_o.codec_id           = video ? held_i.video_byte[3:0] : 4'd0;
    rec_o.packet_type        = video ? held_i.packet_type : 8'd0;
    rec_o.nalu_length        = nalu ? held_i.nalu_length : 32'd0;
    rec_o.video_fields_valid = video;
    rec_o.nalu_valid         = nalu;
  end

endmodule

`default_nettype wire

/* rtl/flv_tag_header_parser_top.sv */
// FLV stream parser, one byte per clock. Each accepted byte goes through a short
// decode step into a result register; a byte is taken every cycle unless a finished
// record waits downstream, so sustained throughput is one byte per cycle and a
// record appears the cycle after the completing byte. The file header gives
// one header record with its ninth byte; every tag gives one tag record with its
// last data byte (or with the last skipped header byte when the tag has no data).
// A byte with the restart flag set is taken as byte 0 of a new file header.
// Depends on flvp_pkg and flvp_record_fmt.
`default_nettype none

module flv_tag_header_parser_top (
  input  wire  logic         clk_i,
  input  wire  logic         rst_ni,
  input  wire  logic         s_axis_tvalid_i,
  output       logic         s_axis_tready_o,
  input  wire  logic [7:0]   s_axis_tdata_i,  // [7:0] data_byte
  input  wire  logic         s_axis_tuser_i,  // [0] restart
  output       logic         m_axis_tvalid_o,
  input  wire  logic         m_axis_tready_i,
  // [39:0] header_word, [71:40] previous_tag_size, [79:72] tag_type,
  // [103:80] data_size, [127:104] timestamp, [131:128] frame_type,
  // [135:132] codec_id, [143:136] packet_type, [175:144] nalu_length,
  // [176] video_fields_valid, [177] nalu_valid, [183:178] zero
  output       logic [flvp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output       logic         m_axis_tuser_o   // [0] record_kind
);
  import flvp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PREV,
    PH_TYPE,
    PH_DSIZE,
    PH_TS,
    PH_SKIP,
    PH_DATA
  } phase_e;

  phase_e             phase_q, phase_d, phase_eff;
  logic [POS_W-1:0]   pos_q, pos_d, pos_eff, pos_inc;
  logic [39:0]        shift_q, shift_d, shift_eff, shift_in;
  flvp_held_t         held_q, held_d;
  flvp_record_t       rec_q, rec_d, tag_rec;
  logic               out_valid_q;
  logic               emit_hdr, emit_tag;
  logic               in_acc;
  logic [7:0]         b;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign b               = s_axis_tdata_i;

  // Restart acts as a reset just ahead of this byte
  assign phase_eff = s_axis_tuser_i ? PH_HEADER : phase_q;
  assign pos_eff   = s_axis_tuser_i ? '0 : pos_q;
  assign shift_eff = s_axis_tuser_i ? '0 : shift_q;
  assign pos_inc   = pos_eff + POS_W'(1);
  assign shift_in  = {shift_eff[31:0], b};

  always_comb begin
    phase_d  = phase_eff;
    pos_d    = pos_inc;
    shift_d  = shift_eff;
    held_d   = held_q;
    emit_hdr = 1'b0;
    emit_tag = 1'b0;
    unique case (phase_eff)
      PH_HEADER: begin
        if (pos_eff < HDR_KEEP_BYTES) begin
          shift_d = shift_in;
        end
        if (pos_inc >= HDR_BYTES) begin
          emit_hdr = 1'b1;
          phase_d  = PH_PREV;
          pos_d    = '0;
          shift_d  = '0;
        end
      end
      PH_PREV: begin
        shift_d = shift_in;
        if (pos_inc >= PREV_BYTES) begin
          held_d.prev_size = shift_in[31:0];
          shift_d          = '0;
          pos_d            = '0;
          phase_d          = PH_TYPE;
        end
      end
      PH_TYPE: begin
        held_d.tag_type    = b;
        held_d.video_byte  = '0;
        held_d.packet_type = '0;
        held_d.nalu_length = '0;
        pos_d              = '0;
        shift_d            = '0;
        phase_d            = PH_DSIZE;
      end
      PH_DSIZE: begin
        shift_d = shift_in;
        if (pos_inc >= DSIZE_BYTES) begin
          held_d.data_size = shift_in[23:0];
          shift_d          = '0;
          pos_d            = '0;
          phase_d          = PH_TS;
        end
      end
      PH_TS: begin
        shift_d = shift_in;
        if (pos_inc >= TS_BYTES) begin
          held_d.timestamp = shift_in[23:0];
          shift_d          = '0;
          pos_d            = '0;
          phase_d          = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (pos_inc >= SKIP_BYTES) begin
          pos_d = '0;
          if (held_q.data_size == '0) begin
            emit_tag = 1'b1;
            phase_d  = PH_PREV;
          end else begin
            phase_d  = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (held_q.tag_type == VIDEO_TAG) begin
          if (pos_eff == VID_BYTE_POS) begin
            held_d.video_byte = b;
          end else if (pos_eff == PKT_TYPE_POS) begin
            held_d.packet_type = b;
          end else if (pos_eff >= NALU_FIRST_POS && pos_eff <= NALU_LAST_POS) begin
            held_d.nalu_length = {held_q.nalu_length[23:0], b};
          end
        end
        if (pos_inc >= held_q.data_size) begin
          emit_tag = 1'b1;
          pos_d    = '0;
          phase_d  = PH_PREV;
        end
      end
      default: begin
        phase_d = PH_HEADER;
        pos_d   = '0;
        shift_d = '0;
      end
    endcase
  end

  flvp_record_fmt u_fmt (
    .held_i (held_d),
    .rec_o  (tag_rec)
  );

  always_comb begin
    rec_d = tag_rec;
    if (emit_hdr) begin
      rec_d             = '0;
      rec_d.record_kind = KIND_HEADER;
      rec_d.header_word = shift_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      shift_q     <= '0;
      held_q      <= '0;
      rec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        shift_q <= shift_d;
        held_q  <= held_d;
      end
      // Load a new record or release the one taken downstream
      if (in_acc && (emit_hdr || emit_tag)) begin
        rec_q       <= rec_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = rec_q.record_kind;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}},
                            rec_q.nalu_valid,
                            rec_q.video_fields_valid,
                            rec_q.nalu_length,
                            rec_q.packet_type,
                            rec_q.codec_id,
                            rec_q.frame_type,
                            rec_q.timestamp,
                            rec_q.data_size,
                            rec_q.tag_type,
                            rec_q.previous_tag_size,
                            rec_q.header_word};

endmodule

`default_nettype wire

/* rtl/flvp_checker.sv */
// Port-level checker for the FLV tag header parser, bound to the top level.
// Depends on flv_tag_header_parser_top_macros.svh and flvp_pkg.
`default_nettype none

`include "flv_tag_header_parser_top_macros.svh"

module flvp_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid_i,
  input wire logic         s_axis_tready_o,
  input wire logic         s_axis_tuser_i,
  input wire logic         m_axis_tvalid_o,
  input wire logic         m_axis_tready_i,
  input wire logic [flvp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic         m_axis_tuser_o
);

  // A waiting record blocks the input side
  `FLVP_ASSERT(a_stall_blocks_input, (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)

  // A restart byte never completes a record in the same transaction
  `FLVP_ASSERT(a_restart_no_record, (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i) |=> (!m_axis_tvalid_o || $past(m_axis_tvalid_o && !m_axis_tready_i)))

  // Hold a stalled record
  `FLVP_ASSERT(a_valid_holds, (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
  `FLVP_ASSERT_HOLD(a_data_holds, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tdata_o)
  `FLVP_ASSERT_HOLD(a_kind_holds, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tuser_o)

endmodule

bind flv_tag_header_parser_top flvp_checker u_flvp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
